// ===== sv/mfe_pkg.sv =====
package mfe_pkg;

  // working widths of the code path
  localparam int X_W     = 24;  // offset value, 0 .. divisor
  localparam int RECIP_W = 26;  // scaled reciprocal
  localparam int CODE_W  = 16;
  localparam int RECIP_SHIFT = 24;

  // 65535 * 2^24, numerator of every reciprocal
  localparam logic [63:0] CODE_SCALE = 64'd65535 << RECIP_SHIFT;

  // command selector
  typedef enum logic [1:0] {
    CMD_MOTION   = 2'd0,
    CMD_ENABLE   = 2'd1,
    CMD_DISABLE  = 2'd2,
    CMD_SET_ZERO = 2'd3
  } cmd_t;

  // frame type codes, identifier bits 28..24
  localparam logic [4:0] TYPE_MOTION  = 5'd1;
  localparam logic [4:0] TYPE_ENABLE  = 5'd3;
  localparam logic [4:0] TYPE_DISABLE = 5'd4;
  localparam logic [4:0] TYPE_ZERO    = 5'd6;

  // register indexes
  localparam logic [7:0] REG_MOTOR_ADDR = 8'd0;
  localparam logic [7:0] REG_HOST_ID    = 8'd1;
  localparam logic [7:0] REG_DIR_REV    = 8'd2;
  localparam logic [7:0] REG_TRQ_SEL    = 8'd3;
  localparam logic [2:0] TRQ_SEL_RESET  = 3'd3;

  // limits and divisors (divisor = 2 * limit for symmetric values)
  localparam int ANG_LIM = 5148672;  // 12.57 rad, q12, times 100
  localparam int VEL_LIM = 81920;    // 20 rad/s in q12
  localparam logic [16:0] KP_LIM = 17'd80000;  // 5000 in q4
  localparam logic [15:0] KD_LIM = 16'd25600;  // 100 in q8

  localparam logic [X_W-1:0] ANG_DIV = 24'd10297344;
  localparam logic [X_W-1:0] VEL_DIV = 24'd163840;
  localparam logic [X_W-1:0] KP_DIV  = 24'd80000;
  localparam logic [X_W-1:0] KD_DIV  = 24'd25600;

  localparam logic [RECIP_W-1:0] ANG_RECIP = RECIP_W'(CODE_SCALE / ANG_DIV);
  localparam logic [RECIP_W-1:0] VEL_RECIP = RECIP_W'(CODE_SCALE / VEL_DIV);
  localparam logic [RECIP_W-1:0] KP_RECIP  = RECIP_W'(CODE_SCALE / KP_DIV);
  localparam logic [RECIP_W-1:0] KD_RECIP  = RECIP_W'(CODE_SCALE / KD_DIV);

  // torque limit per module code: 14, 17, 17, 60, 120, 5.5, 36, 60 Nm in q12
  localparam logic [19:0] TRQ_LIM [8] = '{
    20'd57344, 20'd69632, 20'd69632, 20'd245760,
    20'd491520, 20'd22528, 20'd147456, 20'd245760
  };
  localparam logic [X_W-1:0] TRQ_DIV [8] = '{
    24'd114688, 24'd139264, 24'd139264, 24'd491520,
    24'd983040, 24'd45056, 24'd294912, 24'd491520
  };
  localparam logic [RECIP_W-1:0] TRQ_RECIP [8] = '{
    RECIP_W'(CODE_SCALE / 64'd114688), RECIP_W'(CODE_SCALE / 64'd139264),
    RECIP_W'(CODE_SCALE / 64'd139264), RECIP_W'(CODE_SCALE / 64'd491520),
    RECIP_W'(CODE_SCALE / 64'd983040), RECIP_W'(CODE_SCALE / 64'd45056),
    RECIP_W'(CODE_SCALE / 64'd294912), RECIP_W'(CODE_SCALE / 64'd491520)
  };

  typedef struct packed {
    logic [7:0] target_motor_id;
    logic [7:0] controller_host_id;
    logic       direction_reversed;
    logic [2:0] torque_range_select;
  } cfg_t;

  typedef struct packed {
    logic signed [17:0] angle_target;
    logic signed [17:0] velocity_target;
    logic [16:0]        stiffness_gain;
    logic [15:0]        damping_gain;
    logic signed [20:0] feedforward_torque;
  } item_t;

  typedef struct packed {
    cmd_t cmd;
    logic fault_clr;
  } ctrl_t;

  typedef struct packed {
    logic [X_W-1:0]     ang_x;
    logic [X_W-1:0]     vel_x;
    logic [X_W-1:0]     trq_x;
    logic [X_W-1:0]     kp_x;
    logic [X_W-1:0]     kd_x;
    logic [X_W-1:0]     trq_div;
    logic [RECIP_W-1:0] trq_recip;
  } x_set_t;

  typedef struct packed {
    logic [CODE_W-1:0] ang;
    logic [CODE_W-1:0] vel;
    logic [CODE_W-1:0] trq;
    logic [CODE_W-1:0] kp;
    logic [CODE_W-1:0] kd;
  } codes_t;

  // clamp to [-lim, lim] and shift up by lim
  function automatic logic [X_W-1:0] sat_offset(logic signed [25:0] v,
                                                logic signed [25:0] lim);
    logic signed [25:0] c;
    if (v > lim) begin
      c = lim;
    end else if (v < -lim) begin
      c = -lim;
    end else begin
      c = v;
    end
    return X_W'(c + lim);
  endfunction

endpackage

// ===== sv/mfe_prep.sv =====
module mfe_prep (
  input  mfe_pkg::item_t  item,
  input  mfe_pkg::cfg_t   regs,
  output mfe_pkg::x_set_t xs
);

  logic signed [18:0] ang_ext, ang_dir;
  logic signed [18:0] vel_ext, vel_dir;
  logic signed [21:0] trq_ext, trq_dir;
  logic signed [25:0] ang_sc;
  logic signed [25:0] trq_lim;

  assign ang_ext = 19'(item.angle_target);
  assign vel_ext = 19'(item.velocity_target);
  assign trq_ext = 22'(item.feedforward_torque);

  // reversal at full precision, saturation follows
  assign ang_dir = regs.direction_reversed ? -ang_ext : ang_ext;
  assign vel_dir = regs.direction_reversed ? -vel_ext : vel_ext;
  assign trq_dir = regs.direction_reversed ? -trq_ext : trq_ext;

  // angle limit has two decimals, so compare at 100x
  assign ang_sc  = 26'(ang_dir) * 26'sd100;
  assign trq_lim = signed'(26'(mfe_pkg::TRQ_LIM[regs.torque_range_select]));

  always_comb begin
    xs.ang_x = mfe_pkg::sat_offset(ang_sc, 26'(mfe_pkg::ANG_LIM));
    xs.vel_x = mfe_pkg::sat_offset(26'(vel_dir), 26'(mfe_pkg::VEL_LIM));
    xs.trq_x = mfe_pkg::sat_offset(26'(trq_dir), trq_lim);
    xs.kp_x  = (item.stiffness_gain > mfe_pkg::KP_LIM) ?
               mfe_pkg::X_W'(mfe_pkg::KP_LIM) : mfe_pkg::X_W'(item.stiffness_gain);
    xs.kd_x  = (item.damping_gain > mfe_pkg::KD_LIM) ?
               mfe_pkg::X_W'(mfe_pkg::KD_LIM) : mfe_pkg::X_W'(item.damping_gain);
    xs.trq_div   = mfe_pkg::TRQ_DIV[regs.torque_range_select];
    xs.trq_recip = mfe_pkg::TRQ_RECIP[regs.torque_range_select];
  end

endmodule

// ===== sv/mfe_code_unit.sv =====
// floor(x * 65535 / divisor) for 0 <= x <= divisor
module mfe_code_unit (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mfe_pkg::X_W-1:0]      x,
  input  logic [mfe_pkg::RECIP_W-1:0]  recip,
  input  logic [mfe_pkg::X_W-1:0]      divisor,
  output logic [mfe_pkg::CODE_W-1:0]   code
);

  localparam int PROD_W = mfe_pkg::X_W + mfe_pkg::RECIP_W;
  localparam int NUM_W  = mfe_pkg::X_W + mfe_pkg::CODE_W;

  logic [PROD_W-1:0]          prod;
  logic [mfe_pkg::CODE_W-1:0] q_est;
  logic [mfe_pkg::X_W-1:0]    x_r;
  logic [mfe_pkg::X_W-1:0]    div_r;
  logic [NUM_W-1:0]           num;
  logic [NUM_W-1:0]           q_prod;
  logic [NUM_W-1:0]           rem;

  // estimate is exact or one low
  assign prod = PROD_W'(x) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (en) begin
      q_est <= prod[mfe_pkg::RECIP_SHIFT +: mfe_pkg::CODE_W];
      x_r   <= x;
      div_r <= divisor;
    end
  end

  assign num    = (NUM_W'(x_r) << mfe_pkg::CODE_W) - NUM_W'(x_r);
  assign q_prod = NUM_W'(q_est) * NUM_W'(div_r);
  assign rem    = num - q_prod;
  assign code   = q_est + mfe_pkg::CODE_W'(rem >= NUM_W'(div_r));

endmodule

// ===== sv/mfe_frame_pack.sv =====
module mfe_frame_pack (
  input  mfe_pkg::ctrl_t  ctrl,
  input  mfe_pkg::codes_t codes,
  input  mfe_pkg::cfg_t   regs,
  output logic [28:0]     frame_id,
  output logic [63:0]     frame_payload
);

  logic [4:0]  id_type;
  logic [15:0] data_word;

  always_comb begin
    id_type       = mfe_pkg::TYPE_MOTION;
    data_word     = codes.trq;
    frame_payload = {codes.ang, codes.vel, codes.kp, codes.kd};
    unique case (ctrl.cmd)
      mfe_pkg::CMD_MOTION: begin
      end
      mfe_pkg::CMD_ENABLE: begin
        id_type       = mfe_pkg::TYPE_ENABLE;
        data_word     = 16'(regs.controller_host_id);
        frame_payload = '0;
      end
      mfe_pkg::CMD_DISABLE: begin
        id_type       = mfe_pkg::TYPE_DISABLE;
        data_word     = 16'(regs.controller_host_id);
        frame_payload = {7'd0, ctrl.fault_clr, 56'd0};
      end
      mfe_pkg::CMD_SET_ZERO: begin
        id_type       = mfe_pkg::TYPE_ZERO;
        data_word     = 16'(regs.controller_host_id);
        frame_payload = {8'd1, 56'd0};
      end
      default: begin
      end
    endcase
  end

  assign frame_id = {id_type, data_word, regs.target_motor_id};

endmodule

// ===== sv/motor_command_frame_encoder.sv =====
// Motor command frame encoder. Each command transaction on the input stream
// yields exactly one CAN extended frame (29-bit identifier plus 8 data bytes)
// on the output stream, in order. A new command can be taken every cycle while
// no stall holds the pipeline. The datapath is four register stages: input
// register, saturation/offset, reciprocal multiply, and a correction multiply
// feeding the output register; the two multiplier stages set the depth. Each
// stage moves on when the one after it is empty or moving, so bubbles close up
// and input is taken while a finished frame waits at the output, as long as
// an earlier stage is empty. Configuration registers are read live and must
// only be written while no command is in flight.
module motor_command_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // angle_target[17:0], velocity_target[35:18], stiffness_gain[52:36],
  // damping_gain[68:53], feedforward_torque[89:69], fault_clr[90], zero pad
  input  logic [95:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  // frame stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_id[28:0], frame_payload[92:29], zero pad
  output logic [95:0] m_axis_tdata,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  mfe_pkg::cfg_t   regs;

  // stage enables, chained back from the output
  logic adv_in, adv_x, adv_q, adv_out;

  // input register
  logic            in_valid;
  mfe_pkg::item_t  in_item;
  mfe_pkg::ctrl_t  in_ctrl;

  // saturated, offset values
  logic            x_valid;
  mfe_pkg::x_set_t xs_comb;
  mfe_pkg::x_set_t xs;
  mfe_pkg::ctrl_t  x_ctrl;

  // quotient estimates live inside the code units
  logic            q_valid;
  mfe_pkg::ctrl_t  q_ctrl;
  mfe_pkg::codes_t codes;

  // output register
  logic            out_valid;
  logic [28:0]     frame_id;
  logic [63:0]     frame_payload;

  assign adv_out = !out_valid || m_axis_tready;
  assign adv_q   = !q_valid   || adv_out;
  assign adv_x   = !x_valid   || adv_q;
  assign adv_in  = !in_valid  || adv_x;

  assign s_axis_tready = adv_in;
  assign m_axis_tvalid = out_valid;
  assign cfg_ready     = 1'b1;

  // register file; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target_motor_id     <= '0;
      regs.controller_host_id  <= '0;
      regs.direction_reversed  <= 1'b0;
      regs.torque_range_select <= mfe_pkg::TRQ_SEL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mfe_pkg::REG_MOTOR_ADDR: regs.target_motor_id     <= cfg_data;
        mfe_pkg::REG_HOST_ID:    regs.controller_host_id  <= cfg_data;
        mfe_pkg::REG_DIR_REV:    regs.direction_reversed  <= cfg_data[0];
        mfe_pkg::REG_TRQ_SEL:    regs.torque_range_select <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      x_valid   <= 1'b0;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in)  in_valid  <= s_axis_tvalid;
      if (adv_x)   x_valid   <= in_valid;
      if (adv_q)   q_valid   <= x_valid;
      if (adv_out) out_valid <= q_valid;
    end
  end

  // capture the command transaction
  always_ff @(posedge clk) begin
    if (adv_in) begin
      in_item.angle_target       <= s_axis_tdata[17:0];
      in_item.velocity_target    <= s_axis_tdata[35:18];
      in_item.stiffness_gain     <= s_axis_tdata[52:36];
      in_item.damping_gain       <= s_axis_tdata[68:53];
      in_item.feedforward_torque <= s_axis_tdata[89:69];
      in_ctrl.fault_clr          <= s_axis_tdata[90];
      in_ctrl.cmd                <= mfe_pkg::cmd_t'(s_axis_tuser);
    end
  end

  mfe_prep u_prep (
    .item (in_item),
    .regs (regs),
    .xs   (xs_comb)
  );

  always_ff @(posedge clk) begin
    if (adv_x) begin
      xs     <= xs_comb;
      x_ctrl <= in_ctrl;
    end
  end

  // one divide unit per code; torque takes its divisor from the range select
  mfe_code_unit u_ang (
    .clk (clk), .en (adv_q), .x (xs.ang_x),
    .recip (mfe_pkg::ANG_RECIP), .divisor (mfe_pkg::ANG_DIV), .code (codes.ang)
  );

  mfe_code_unit u_vel (
    .clk (clk), .en (adv_q), .x (xs.vel_x),
    .recip (mfe_pkg::VEL_RECIP), .divisor (mfe_pkg::VEL_DIV), .code (codes.vel)
  );

  mfe_code_unit u_trq (
    .clk (clk), .en (adv_q), .x (xs.trq_x),
    .recip (xs.trq_recip), .divisor (xs.trq_div), .code (codes.trq)
  );

  mfe_code_unit u_kp (
    .clk (clk), .en (adv_q), .x (xs.kp_x),
    .recip (mfe_pkg::KP_RECIP), .divisor (mfe_pkg::KP_DIV), .code (codes.kp)
  );

  mfe_code_unit u_kd (
    .clk (clk), .en (adv_q), .x (xs.kd_x),
    .recip (mfe_pkg::KD_RECIP), .divisor (mfe_pkg::KD_DIV), .code (codes.kd)
  );

  always_ff @(posedge clk) begin
    if (adv_q) begin
      q_ctrl <= x_ctrl;
    end
  end

  mfe_frame_pack u_pack (
    .ctrl          (q_ctrl),
    .codes         (codes),
    .regs          (regs),
    .frame_id      (frame_id),
    .frame_payload (frame_payload)
  );

  // output register holds the frame until its transaction completes
  always_ff @(posedge clk) begin
    if (adv_out) begin
      m_axis_tdata <= {3'd0, frame_payload, frame_id};
    end
  end

endmodule

// ===== sv/mfe_checker.sv =====
module mfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // a frame only carries one of the four type codes
  a_id_type: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[28:24] == mfe_pkg::TYPE_MOTION ||
                       m_axis_tdata[28:24] == mfe_pkg::TYPE_ENABLE ||
                       m_axis_tdata[28:24] == mfe_pkg::TYPE_DISABLE ||
                       m_axis_tdata[28:24] == mfe_pkg::TYPE_ZERO))
    else $error("frame type code out of set");

  // enable frames have an empty payload
  a_enable_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[28:24] == mfe_pkg::TYPE_ENABLE
    |-> m_axis_tdata[92:29] == 64'd0)
    else $error("enable frame with nonzero payload");

  // a draining output never blocks the input side
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output frame changed while stalled");

endmodule

bind motor_command_frame_encoder mfe_checker u_mfe_checker (.*);
